// File: src/epwef_pkg.sv
// Package of types, constants and helpers for the echo profile wall edge finder.
package epwef_pkg;

   // Block constants.
   localparam int LAG         = 20;
   localparam int MAX_SAMPLES = 1024;
   localparam int SAMPLE_W    = 8;
   localparam int WALL_W      = 10;

   // Derived widths.
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int POS_W  = $clog2(MAX_SAMPLES);
   localparam int STEP_W = $clog2(LAG + 1);
   localparam int SUM_W  = CNT_W + 1;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [STEP_W-1:0]   step_type;

   // One input transfer.
   typedef struct packed {
      sample_type sample;
      logic       last;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [WALL_W-1:0] wall_index;
      logic              too_long;
   } rsp_type;

   // Outcome of the shared drop unit.
   typedef struct packed {
      logic       win;
      sample_type drop;
   } drop_result_type;

   typedef enum logic [1:0] {
      ST_STREAM,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Maps an internal position onto the result field, keeping the low bits.
   function automatic logic [WALL_W-1:0] to_wall_index(input pos_type pos);
      logic [31:0] wide;
      wide = 32'(pos);
      return wide[WALL_W-1:0];
   endfunction

endpackage

// File: src/epwef_drop_unit.sv
// Shared subtract and compare unit that scores one drop against the best so far.
module epwef_drop_unit
   import epwef_pkg::*;
(
   input  sample_type      upper,
   input  sample_type      lower,
   input  sample_type      best_drop,
   output drop_result_type result
);

   logic [SAMPLE_W:0] diff;

   // The drop wins only if it is positive and strictly larger than the best.
   always_comb begin
      diff        = {1'b0, upper} - {1'b0, lower};
      result.drop = diff[SAMPLE_W-1:0];
      result.win  = !diff[SAMPLE_W] && (diff[SAMPLE_W-1:0] > best_drop);
   end

endmodule

// File: src/epwef_delay_line.sv
// Shift line holding the most recent LAG samples of the profile.
module epwef_delay_line
   import epwef_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  sample_type din,
   output sample_type oldest,
   output sample_type newest
);

   sample_type taps_ff [LAG];

   // Tap zero takes the new sample; every other tap takes its neighbour.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         taps_ff[0] <= din;
         for (int i = 1; i < LAG; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

   assign oldest = taps_ff[LAG-1];
   assign newest = taps_ff[0];

endmodule

// File: src/echo_profile_wall_edge_finder.sv
// Top level of the echo profile wall edge finder.
// The block takes one sample per cycle while a profile streams in, scoring each
// drop s[k] - s[k+LAG] through one shared subtract and compare unit as the later
// sample arrives. The transfer carrying the last flag starts a tail scan that
// rotates the LAG-entry delay line through the same unit, one entry per cycle,
// against the final kept sample; the scan is followed by placing the result in
// the output register, and no sample is taken during either. If the previous
// result is still held in the output register and is not taken, placing the
// new result waits until it is. The next profile may start while the previous
// result still waits in the output register.
module echo_profile_wall_edge_finder
   import epwef_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type       state_ff, state_in;
   count_type       count_ff, count_in;
   sample_type      best_drop_ff, best_drop_in;
   pos_type         best_pos_ff, best_pos_in;
   logic            overflow_ff, overflow_in;
   step_type        step_ff, step_in;
   sample_type      stand_in_ff, stand_in_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            kept;
   logic            scan_active;
   logic            load_rsp;
   logic            score_en;
   pos_type         score_pos;
   sample_type      unit_upper, unit_lower;
   drop_result_type unit_result;
   logic            line_shift;
   sample_type      line_din, line_oldest, line_newest;
   logic [SUM_W-1:0] scan_sum;

   assign accept = req_valid && req_ready;
   assign kept   = count_ff < CNT_W'(MAX_SAMPLES);

   // Delay line: pushes kept samples, rotates during the tail scan.
   assign line_shift = (accept && kept) || scan_active;
   assign line_din   = scan_active ? line_oldest : req_data.sample;

   epwef_delay_line u_delay_line (
      .clock    (clock),
      .shift_en (line_shift),
      .din      (line_din),
      .oldest   (line_oldest),
      .newest   (line_newest)
   );

   // Operand selection for the shared drop unit.
   assign scan_sum   = SUM_W'(count_ff) + SUM_W'(step_ff);
   assign unit_upper = line_oldest;
   assign unit_lower = scan_active ? stand_in_ff : req_data.sample;

   always_comb begin
      if (scan_active) begin
         score_en  = scan_sum >= SUM_W'(2 * LAG);
         score_pos = POS_W'(scan_sum - SUM_W'(LAG));
      end else begin
         score_en  = accept && kept && (count_ff >= CNT_W'(2 * LAG));
         score_pos = POS_W'(count_ff - CNT_W'(LAG));
      end
   end

   epwef_drop_unit u_drop_unit (
      .upper     (unit_upper),
      .lower     (unit_lower),
      .best_drop (best_drop_ff),
      .result    (unit_result)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_STREAM: begin
            if (accept && req_data.last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == STEP_W'(LAG - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_STREAM;
            end
         end
         default: state_in = ST_STREAM;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready   = 1'b0;
      scan_active = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_STREAM: req_ready   = 1'b1;
         ST_SCAN:   scan_active = 1'b1;
         ST_DONE:   load_rsp    = !rsp_valid_ff || rsp_ready;
         default:   req_ready   = 1'b0;
      endcase
   end

   // Profile state: count, best drop and its position, overflow, stand-in.
   always_comb begin
      count_in     = count_ff;
      best_drop_in = best_drop_ff;
      best_pos_in  = best_pos_ff;
      overflow_in  = overflow_ff;
      stand_in_in  = stand_in_ff;
      step_in      = step_ff;
      if (score_en && unit_result.win) begin
         best_drop_in = unit_result.drop;
         best_pos_in  = score_pos;
      end
      if (accept) begin
         if (kept) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
         if (req_data.last) begin
            stand_in_in = kept ? req_data.sample : line_newest;
            step_in     = '0;
         end
      end
      if (scan_active) begin
         step_in = step_ff + STEP_W'(1);
      end
      if (load_rsp) begin
         count_in     = '0;
         best_drop_in = '0;
         best_pos_in  = POS_W'(LAG);
         overflow_in  = 1'b0;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.wall_index = to_wall_index(best_pos_ff);
         rsp_data_in.too_long   = overflow_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_STREAM;
         count_ff     <= '0;
         best_drop_ff <= '0;
         best_pos_ff  <= POS_W'(LAG);
         overflow_ff  <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_drop_ff <= best_drop_in;
         best_pos_ff  <= best_pos_in;
         overflow_ff  <= overflow_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stand_in_ff <= stand_in_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // The final sample always starts the tail scan from its first step.
   a_last_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last) |=> (state_ff == ST_SCAN && step_ff == '0))
      else $error("last sample did not start the tail scan");

   // The tail scan ends after exactly LAG steps.
   a_scan_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && step_ff == STEP_W'(LAG - 1)) |=> (state_ff == ST_DONE))
      else $error("tail scan did not end after LAG steps");

   // With no positive drop recorded, the position stays at its default.
   a_default_position: assert property (@(posedge clock) disable iff (reset)
      (best_drop_ff == '0) |-> (best_pos_ff == POS_W'(LAG)))
      else $error("position moved without a positive drop");

   // The kept sample count never passes the profile limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count passed the profile limit");
`endif

endmodule

// File: bench/echo_profile_wall_edge_finder_test.sv
// Self-checking testbench for the echo profile wall edge finder.
`timescale 1ns / 1ps

module echo_profile_wall_edge_finder_test;
   import epwef_pkg::*;

   localparam int ITEM_TARGET  = 1900;
   localparam int MIN_PROFILES = 30;
   localparam int SETTLE_LIMIT = 4 * (LAG + 1);

   // Content patterns used to build random profiles.
   typedef enum int {
      SHAPE_NOISE,
      SHAPE_WALL,
      SHAPE_STEPS,
      SHAPE_FLAT,
      SHAPE_RAILS
   } shape_type;

   // One sample waiting to be driven, with its idling phase and an optional hold-off.
   typedef struct {
      req_type beat;
      int      phase;
      bit      drain;
   } staged_sample_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   staged_sample_type pending_samples [$];
   rsp_type           expected_walls [$];
   rsp_type           wanted_wall;

   // Idle percentages per phase for the sender and the receiver.
   int send_idle_pct [3] = '{16, 55, 0};
   int recv_stall_pct [3] = '{55, 16, 0};
   int phase = 0;
   logic req_taken;

   // Predictor state for the profile in flight.
   sample_type  echo_history [LAG];
   int unsigned kept_samples;
   int unsigned top_drop;
   int unsigned top_position;
   bit          cut_short;

   int queued = 0;
   int profiles = 0;
   int long_profiles = 0;
   int short_profiles = 0;
   int samples_taken = 0;
   int walls_checked = 0;
   int mismatch_count = 0;

   echo_profile_wall_edge_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prints one line per mismatch and keeps the count.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Keeps the first strictly largest positive drop.
   task automatic rank_drop(input int unsigned pos, input int unsigned a, input int unsigned b);
      if (a > b && (a - b) > top_drop) begin
         top_drop = a - b;
         top_position = pos;
      end
   endtask

   task automatic clear_profile_state();
      kept_samples = 0;
      top_drop = 0;
      top_position = LAG;
      cut_short = 1'b0;
   endtask

   // Updates the predicted state for one accepted sample and, on the last one,
   // queues the expected wall position.
   task automatic predict_wall_edge(input req_type beat);
      int unsigned j;
      int unsigned n;
      int unsigned k;
      int unsigned stand_in;
      rsp_type     wall;
      if (kept_samples < MAX_SAMPLES) begin
         j = kept_samples;
         if (j >= 2 * LAG)
            rank_drop(j - LAG, echo_history[j % LAG], beat.sample);
         echo_history[j % LAG] = beat.sample;
         kept_samples = j + 1;
      end else begin
         cut_short = 1'b1;
      end
      if (beat.last) begin
         // Tail scan: the final kept sample stands in past the end of the profile.
         n = kept_samples;
         stand_in = echo_history[(n - 1) % LAG];
         k = (n > LAG) ? n - LAG : 0;
         if (k < LAG)
            k = LAG;
         for (; k < n; k++)
            rank_drop(k, echo_history[k % LAG], stand_in);
         wall.wall_index = top_position[WALL_W-1:0];
         wall.too_long = cut_short;
         expected_walls.push_back(wall);
         clear_profile_state();
      end
   endtask

   task automatic queue_item(input sample_type value, input logic is_last, input bit drain);
      staged_sample_type entry;
      entry.beat.sample = value;
      entry.beat.last = is_last;
      entry.drain = drain;
      entry.phase = (queued * 3) / ITEM_TARGET;
      if (entry.phase > 2)
         entry.phase = 2;
      pending_samples.push_back(entry);
      queued++;
   endtask

   // Builds one profile of the given length and content pattern.
   task automatic queue_profile(input int len, input shape_type shape, input bit drain);
      int         hi;
      int         lo;
      int         drop_at;
      int         period;
      int         idx;
      sample_type s;
      hi = $urandom_range(255, 100);
      lo = $urandom_range(60, 0);
      drop_at = $urandom_range(len - 1, 0);
      period = $urandom_range(10, 2);
      for (idx = 0; idx < len; idx++) begin
         case (shape)
            SHAPE_WALL: begin
               if (idx < drop_at)
                  s = sample_type'(hi - $urandom_range(7, 0));
               else
                  s = sample_type'(lo + $urandom_range(7, 0));
            end
            SHAPE_STEPS: s = ((idx / period) % 2 == 0) ? sample_type'(hi) : sample_type'(lo);
            SHAPE_FLAT:  s = sample_type'(hi);
            SHAPE_RAILS: s = $urandom_range(1) ? 8'hFF : 8'h00;
            default:     s = sample_type'($urandom_range(255));
         endcase
         queue_item(s, idx == len - 1, drain && idx == 0);
      end
      profiles++;
      if (len > MAX_SAMPLES)
         long_profiles++;
      else if (len <= LAG)
         short_profiles++;
   endtask

   // Driver: presents the next staged sample once the previous transfer is done.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0
             && !(pending_samples[0].drain && expected_walls.size() != 0)
             && $urandom_range(99) >= send_idle_pct[pending_samples[0].phase]) begin
            req_data <= pending_samples[0].beat;
            req_valid <= 1'b1;
            phase <= pending_samples[0].phase;
            void'(pending_samples.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct[phase]);
   end

   // Monitor: predicts on each accepted sample and checks each accepted result.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_wall_edge(req_data);
            samples_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_walls.size() == 0) begin
               report_mismatch("unexpected result wall_index", rsp_data.wall_index, -1);
            end else begin
               wanted_wall = expected_walls.pop_front();
               walls_checked++;
               if (rsp_data.wall_index !== wanted_wall.wall_index)
                  report_mismatch("wall_index", rsp_data.wall_index, wanted_wall.wall_index);
               if (rsp_data.too_long !== wanted_wall.too_long)
                  report_mismatch("too_long", rsp_data.too_long, wanted_wall.too_long);
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int k;
      int len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      clear_profile_state();

      // Directed: single-sample profile at full scale.
      queue_item(8'hFF, 1'b1, 1'b0);
      profiles++;
      short_profiles++;
      // Directed: two-sample rising profile, no position scored.
      queue_item(8'h00, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b0);
      profiles++;
      short_profiles++;
      // Directed: full-scale drop at the first scored position, found by the tail scan.
      for (k = 0; k < LAG; k++)
         queue_item(sample_type'(k * 13), 1'b0, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b0);
      profiles++;

      // Random profiles, with one that runs past the sample limit.
      while (queued < ITEM_TARGET || profiles < MIN_PROFILES) begin
         if (profiles == 12 && long_profiles == 0) begin
            queue_profile(MAX_SAMPLES + $urandom_range(6, 1),
                          shape_type'($urandom_range(1, 0)), 1'b0);
         end else begin
            case ($urandom_range(9))
               0:       len = $urandom_range(LAG, 1);
               1:       len = $urandom_range(LAG + 2, LAG);
               2:       len = $urandom_range(2 * LAG + 2, 2 * LAG - 1);
               default: len = $urandom_range(50, 1);
            endcase
            queue_profile(len, shape_type'($urandom_range(4)),
                          profiles == 3 || $urandom_range(7) == 0);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all samples to go, all results to arrive, then a quiet spell.
      while (pending_samples.size() != 0 || req_valid)
         @(negedge clock);
      while (expected_walls.size() != 0)
         @(negedge clock);
      repeat (SETTLE_LIMIT) @(negedge clock);

      $display("Covered %0d samples in %0d profiles (%0d short, %0d over the limit).",
               samples_taken, profiles, short_profiles, long_profiles);
      $display("Checked %0d wall results, %0d mismatches.", walls_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
